[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion helpers, all clocked on the rising edge and quiet during reset.
`ifndef NO_ASSERTIONS
`define BBPA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bbpa assertion failed");
`define BBPA_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bbpa forbidden condition seen");
`else
`define BBPA_ASSERT(lbl, clk, rst_n, prop)
`define BBPA_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[design/bbpa_pkg.sv]
package bbpa_pkg;

	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 16;
	localparam int COUNT_W = 7;
	localparam int ROW_W   = 32;
	localparam int BIT_W   = 5;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
	localparam logic [1:0] ST_BAD_FREE   = 2'd2;

	localparam logic [1:0] CFG_POOL_BASE   = 2'd0;
	localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd1;
	localparam logic [1:0] CFG_BLOCK_COUNT = 2'd2;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] req_size;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] block_addr;
	} rsp_t;

endpackage

[design/bitmap_block_pool_allocator.sv]
// Fixed-size block pool allocator. The used flags live in a synchronous
// memory of 32-bit rows; each row has a valid flag cleared by reset, so the pool
// starts all free with no clearing pass. One request is worked at a time and gives
// one response word. An oversized allocate goes straight to the response. Any other
// allocate reads the rows in order, a read state and a check state per row, and
// claims the lowest free live block. A free finds the block index with a
// restoring divider that produces one quotient bit per cycle, in
// max(1, clog2(ceil(MAX_BLOCKS/32)))+5 steps, then reads the block's row and clears
// its flag; a rejected free skips the divider. A new request is taken as soon as the
// previous result sits in the output register; while that register holds an unread
// word, the next result waits in the done state.
`include "assert_macros.svh"

module bitmap_block_pool_allocator
	import bbpa_pkg::*;
#(
	parameter int MAX_BLOCKS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [ADDR_W-1:0] cfg_wdata
);

	localparam int ROWS = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
	localparam int RIW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW   = RIW + BIT_W;
	localparam int CW   = BW + 1;
	localparam int OW   = SIZE_W + BW;
	localparam int KW   = $clog2(BW);

	typedef enum logic [3:0] {
		S_IDLE, S_ARD, S_ACHK, S_AADDR, S_FSPAN, S_FCHK, S_FDIV, S_FRD, S_FWR, S_DONE
	} state_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    pool_base_q;
	logic [SIZE_W-1:0]    block_size_q;
	logic [COUNT_W-1:0]   block_count_q;

	logic [ROW_W-1:0]     mem_q [ROWS];
	logic [ROWS-1:0]      row_vld_q;
	logic [ROW_W-1:0]     mem_rd_q;
	logic                 vld_rd_q;

	logic [ADDR_W-1:0]    addr_q;
	logic [RIW-1:0]       row_q;
	logic [SIZE_W+BW-1:0] prod_s1;
	logic [SIZE_W+CW-1:0] span_q;
	logic [ADDR_W:0]      off_q;
	logic [OW-1:0]        rem_q;
	logic [OW-1:0]        dsor_q;
	logic [BW-1:0]        quo_q;
	logic [KW-1:0]        step_q;
	logic [1:0]           status_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic [CW-1:0]        live_n;
	logic [RIW-1:0]       rd_addr;
	logic [ROW_W-1:0]     row_data;
	logic [ROW_W-1:0]     live_mask;
	logic [ROW_W-1:0]     free_bits;
	logic [BIT_W-1:0]     pick;
	logic                 found;
	logic                 wr_en;
	logic [RIW-1:0]       wr_addr;
	logic [ROW_W-1:0]     wr_data;
	logic                 rsp_free;
	logic                 dsor_fits;

	assign live_n = (32'(block_count_q) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(block_count_q);
	assign row_data = vld_rd_q ? mem_rd_q : '0;
	assign rd_addr = (state_q == S_FRD) ? quo_q[BW-1:BIT_W] : row_q;
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign dsor_fits = (rem_q >= dsor_q);

	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			live_mask[j] = (CW'({row_q, BIT_W'(j)}) < live_n);
		end
		free_bits = ~row_data & live_mask;
		found = |free_bits;
		pick = '0;
		for (int j = ROW_W - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				pick = BIT_W'(j);
			end
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = row_q;
		wr_data = row_data;
		if (state_q == S_ACHK && found) begin
			wr_en = 1'b1;
			wr_data[pick] = 1'b1;
		end else if (state_q == S_FWR) begin
			wr_en = 1'b1;
			wr_addr = quo_q[BW-1:BIT_W];
			wr_data[quo_q[BIT_W-1:0]] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mem_rd_q <= mem_q[rd_addr];
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= row_vld_q[rd_addr];
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			block_size_q <= SIZE_W'(64);
			block_count_q <= COUNT_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_POOL_BASE:   pool_base_q <= cfg_wdata;
				CFG_BLOCK_SIZE:  block_size_q <= cfg_wdata[SIZE_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						addr_q <= req.free_addr;
						row_q <= '0;
						res_addr_q <= '0;
						if (req.cmd == CMD_FREE) begin
							state_q <= S_FSPAN;
						end else if (req.req_size > ADDR_W'(block_size_q)) begin
							status_q <= ST_ALLOC_FAIL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ARD;
						end
					end
				end
				S_ARD: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					if (found) begin
						prod_s1 <= (SIZE_W + BW)'(block_size_q) * (SIZE_W + BW)'({row_q, pick});
						state_q <= S_AADDR;
					end else if (row_q == RIW'(ROWS - 1)) begin
						status_q <= ST_ALLOC_FAIL;
						state_q <= S_DONE;
					end else begin
						row_q <= row_q + 1'b1;
						state_q <= S_ARD;
					end
				end
				S_AADDR: begin
					res_addr_q <= pool_base_q + ADDR_W'(prod_s1);
					status_q <= ST_OK;
					state_q <= S_DONE;
				end
				S_FSPAN: begin
					span_q <= (SIZE_W + CW)'(block_size_q) * (SIZE_W + CW)'(live_n);
					off_q <= {1'b0, addr_q} - {1'b0, pool_base_q};
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					rem_q <= off_q[OW-1:0];
					dsor_q <= OW'(block_size_q) << (BW - 1);
					quo_q <= '0;
					step_q <= KW'(BW - 1);
					if (addr_q == '0 || off_q[ADDR_W] || off_q >= (ADDR_W + 1)'(span_q)) begin
						status_q <= ST_BAD_FREE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (dsor_fits) begin
						rem_q <= rem_q - dsor_q;
					end
					quo_q <= {quo_q[BW-2:0], dsor_fits};
					dsor_q <= dsor_q >> 1;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					status_q <= ST_OK;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q.status <= status_q;
						rsp_q.block_addr <= res_addr_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BBPA_ASSERT(a_pick_free, clk, arst_n, (state_q == S_ACHK && found) |-> free_bits[pick])
	`BBPA_ASSERT(a_quo_live, clk, arst_n, (state_q == S_FRD) |-> (CW'(quo_q) < live_n))
	`BBPA_ASSERT(a_req_busy, clk, arst_n, (req_valid && req_ready) |=> (state_q != S_IDLE))
	`BBPA_NEVER(a_bad_status, clk, arst_n, rsp_valid_q && rsp_q.status == 2'd3)

endmodule
